[src/torus_distance_field_step_unit_assert.svh]
// Assertion macros for the torus distance field step unit.
// Both expect clk and rst_n in the scope of the use.
`ifndef TORUS_DISTANCE_FIELD_STEP_UNIT_ASSERT_SVH
`define TORUS_DISTANCE_FIELD_STEP_UNIT_ASSERT_SVH

// Same-cycle implication
`define TDF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/tdf_pkg.sv]
`default_nettype none

package tdf_pkg;

    // Default datapath format, Q16.16 in 32 bits
    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // Register map (index = byte address / register stride)
    typedef enum logic [2:0] {
        REG_CONTROL      = 3'd0,
        REG_MAJOR        = 3'd1,
        REG_MINOR        = 3'd2,
        REG_SHELL        = 3'd3,
        REG_DER_OFFSET   = 3'd4,
        REG_COL_BASE     = 3'd5,
        REG_COL_PER_ITER = 3'd6,
        REG_COL_SHELL    = 3'd7
    } reg_idx_t;

    // Control register bit positions
    localparam int CTL_SWAPXZ    = 0;
    localparam int CTL_SWAPYZ    = 1;
    localparam int CTL_SHELL     = 2;
    localparam int CTL_CHEBYSHEV = 3;
    localparam int CTL_CLIPX     = 4;
    localparam int CTL_CLIPY     = 5;
    localparam int CTL_COLOUR    = 6;
    localparam int CTL_ACCUM     = 7;
    localparam int CTL_START_LSB = 8;
    localparam int CTL_STOP_LSB  = 16;
    localparam int CTL_WIDTH     = 24;

    // Shared pipeline control: stage advance and beat valid at the unit input
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

[src/tdf_isqrt.sv]
`default_nettype none

// Pipelined floor square root, one root bit per stage.
module tdf_isqrt #(
    parameter int W      = tdf_pkg::DEF_WORD_WIDTH,
    parameter int SIDE_W = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tdf_pkg::pipe_ctl_t    ctl,
    input  wire logic [2*W-1:0]        rad,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [W-1:0]               root,
    output logic [SIDE_W-1:0]          side_out
);

    logic [W+1:0]    rem_reg  [0:W-1];
    logic [W-1:0]    root_reg [0:W-1];
    logic [2*W-1:0]  rad_reg  [0:W-1];
    logic [SIDE_W-1:0] side_reg [0:W-1];
    logic            vld_reg  [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+1:0]      rem_s;
        logic [W-1:0]      root_s;
        logic [2*W-1:0]    rad_s;
        logic [SIDE_W-1:0] side_s;
        logic              vld_s;
        logic [W+1:0]      rem_sh;
        logic [W+1:0]      trial;
        logic              ge;
        logic [W+1:0]      rem_next;
        logic [W-1:0]      root_next;

        if (k == 0) begin : g_first
            assign rem_s  = '0;
            assign root_s = '0;
            assign rad_s  = rad;
            assign side_s = side_in;
            assign vld_s  = ctl.valid;
        end
        else begin : g_next
            assign rem_s  = rem_reg[k-1];
            assign root_s = root_reg[k-1];
            assign rad_s  = rad_reg[k-1];
            assign side_s = side_reg[k-1];
            assign vld_s  = vld_reg[k-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh    = {rem_s[W-1:0], rad_s[2*W-1 -: 2]};
        assign trial     = {root_s, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_s[W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                vld_reg[k] <= vld_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_s[2*W-3:0], 2'b00};
                side_reg[k] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign root      = root_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

`default_nettype wire

[src/tdf_div.sv]
`default_nettype none

// Pipelined restoring divider of (num << F) by den, one quotient bit per stage.
module tdf_div #(
    parameter int W      = tdf_pkg::DEF_WORD_WIDTH,
    parameter int F      = tdf_pkg::DEF_FRAC_BITS,
    parameter int SIDE_W = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tdf_pkg::pipe_ctl_t    ctl,
    input  wire logic [W-1:0]          num,
    input  wire logic [W-1:0]          den,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [W+F-1:0]             quo,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int NW = W + F;

    logic [W-1:0]      rem_reg  [0:NW-1];
    logic [NW-1:0]     quo_reg  [0:NW-1];
    logic [NW-1:0]     num_reg  [0:NW-1];
    logic [W-1:0]      den_reg  [0:NW-1];
    logic [SIDE_W-1:0] side_reg [0:NW-1];
    logic              vld_reg  [0:NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [W-1:0]      rem_s;
        logic [NW-1:0]     quo_s;
        logic [NW-1:0]     num_s;
        logic [W-1:0]      den_s;
        logic [SIDE_W-1:0] side_s;
        logic              vld_s;
        logic [W:0]        rem_sh;
        logic              ge;
        logic [W:0]        rem_diff;

        if (k == 0) begin : g_first
            assign rem_s  = '0;
            assign quo_s  = '0;
            assign num_s  = {num, {F{1'b0}}};
            assign den_s  = den;
            assign side_s = side_in;
            assign vld_s  = ctl.valid;
        end
        else begin : g_next
            assign rem_s  = rem_reg[k-1];
            assign quo_s  = quo_reg[k-1];
            assign num_s  = num_reg[k-1];
            assign den_s  = den_reg[k-1];
            assign side_s = side_reg[k-1];
            assign vld_s  = vld_reg[k-1];
        end

        // Shift in next dividend bit, subtract when it fits
        assign rem_sh   = {rem_s, num_s[NW-1]};
        assign ge       = (rem_sh >= {1'b0, den_s});
        assign rem_diff = rem_sh - {1'b0, den_s};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                vld_reg[k] <= vld_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                rem_reg[k]  <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
                quo_reg[k]  <= {quo_s[NW-2:0], ge};
                num_reg[k]  <= {num_s[NW-2:0], 1'b0};
                den_reg[k]  <= den_s;
                side_reg[k] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

`default_nettype wire

[src/torus_distance_field_step_unit.sv]
`default_nettype none
`include "torus_distance_field_step_unit_assert.svh"

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: point x,y,z, distance, derivative, colour, iteration
// m_*       out  m_tvalid/m_tready  m_tdata: new distance, new colour
// APB       in   psel/penable       8 registers, stride 4 bytes (8 when WORD_WIDTH > 32)
//
// One beat per cycle sustained while the skid entry is empty; the depth is set by two
// bit-serial root pipelines and the divider pipeline.
// Reset clears the stage valid bits and the output and skid valid bits, and loads the config defaults.
// The output register plus one skid entry decouple the sides; the whole pipeline
// holds only when the skid entry is full.
module torus_distance_field_step_unit #(
    parameter int WORD_WIDTH = tdf_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = tdf_pkg::DEF_FRAC_BITS,
    localparam int IN_W   = ((6*WORD_WIDTH + 8 + 7) / 8) * 8,
    localparam int OUT_W  = ((2*WORD_WIDTH + 7) / 8) * 8,
    localparam int DW     = (WORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W = (WORD_WIDTH > 32) ? 6 : 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, point_z, running_distance, running_derivative,
    // running_colour, iteration
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // new_distance, new_colour
    output logic [OUT_W-1:0]       m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DW-1:0]     pwdata,
    output logic [DW-1:0]          prdata,
    output logic                   pready
);

    import tdf_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [63:0]  SHELL_RST64 = ((64'd5 << F) + 64'd500) / 64'd1000;
    localparam logic [W-1:0] SHELL_RST = SHELL_RST64[W-1:0];
    localparam logic [W-1:0] MAJOR_RST = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [W-1:0] MINOR_RST = {{(W-1){1'b0}}, 1'b1} << (F-1);

    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] z;
        logic [W-1:0] rdist;
        logic [W-1:0] div;
        logic [W-1:0] col;
        logic [W-1:0] cadd;
        logic [7:0]   it;
    } item_t;

    typedef struct packed {
        logic neg;
        logic numz;
        logic denz;
        logic numneg;
    } qflags_t;

    // Saturating helpers on W-bit two's complement words
    function automatic logic [W-1:0] sat1(input logic [W:0] s);
        if (s[W] != s[W-1])
            return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat1({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat1({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] sneg(input logic [W-1:0] a);
        return (a == MINV) ? MAXV : (~a + 1'b1);
    endfunction

    function automatic logic [W-1:0] sabs(input logic [W-1:0] a);
        return a[W-1] ? sneg(a) : a;
    endfunction

    function automatic logic [W-1:0] magn(input logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [W-1:0] smax(input logic [W-1:0] a, input logic [W-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic logic [W-1:0] rsat(input logic [W-1:0] r);
        return r[W-1] ? MAXV : r;
    endfunction

    // Configuration registers
    logic [CTL_WIDTH-1:0] ctrl_reg;
    logic [W-1:0] major_reg, minor_reg, shellt_reg, doff_reg;
    logic [W-1:0] cbase_reg, citer_reg, cextra_reg;
    logic         cfg_wr;
    reg_idx_t     cfg_idx;
    logic [W-1:0] rd_word;
    logic [W-1:0] toff;
    logic         shell_on;

    // Pipeline control
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg, v12_reg, v13_reg;
    logic sq1_valid, sq2_valid, dv_valid;

    // Stage payloads
    item_t item1_reg, item2_reg, item3_reg, item4_reg, item5_reg, item6_reg;
    item_t item7_reg, item8_reg, item9_reg, item10_reg, item11_reg, item12_reg;
    item_t item13_reg;
    item_t item1_next, item2_next, item4_next, item12_next;
    item_t sq1_item, sq2_item, dv_item;
    logic [W-1:0]   mx2_reg, my2_reg, mx2_next, my2_next;
    logic signed [W+8:0] prod2_reg, prod2_next;
    logic [2*W-1:0] sqx3_reg, sqy3_reg;
    logic [W-1:0]   cis3_reg, cis3_next;
    logic [2*W-1:0] rad4_reg;
    logic [W-1:0]   root1, root2;
    logic [W-1:0]   t1_5_reg, t1_5_next;
    logic [W-1:0]   mt6_reg, mz6_reg, cheb6_reg, cheb6_next;
    logic [2*W-1:0] sqt7_reg, sqz7_reg;
    logic [W-1:0]   cheb7_reg, cheb8_reg, sq2_cheb;
    logic [2*W-1:0] rad8_reg;
    logic [W-1:0]   raw9_reg, raw9_next;
    logic [W-1:0]   torsh10_reg, torsh10_next, rawp10_reg, rawp10_next;
    logic [W-1:0]   torf11_reg, torf11_next;
    logic           extra11_reg, extra11_next;
    logic [W-1:0]   nm12_reg, dm12_reg;
    qflags_t        qf12_reg, qf12_next, dv_qf;
    logic [NW-1:0]  quo;
    logic [W-1:0]   q13_reg, q13_next;

    // Output side
    logic [W-1:0]   nd_out, col_out;
    logic [2*W-1:0] p_data;
    logic           take;
    logic           out_valid_reg, skid_valid_reg;
    logic [2*W-1:0] out_data_reg, skid_data_reg;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1 -: 3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            major_reg  <= MAJOR_RST;
            minor_reg  <= MINOR_RST;
            shellt_reg <= SHELL_RST;
            doff_reg   <= '0;
            cbase_reg  <= '0;
            citer_reg  <= '0;
            cextra_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CONTROL:      ctrl_reg   <= pwdata[CTL_WIDTH-1:0];
                REG_MAJOR:        major_reg  <= pwdata[W-1:0];
                REG_MINOR:        minor_reg  <= pwdata[W-1:0];
                REG_SHELL:        shellt_reg <= pwdata[W-1:0];
                REG_DER_OFFSET:   doff_reg   <= pwdata[W-1:0];
                REG_COL_BASE:     cbase_reg  <= pwdata[W-1:0];
                REG_COL_PER_ITER: citer_reg  <= pwdata[W-1:0];
                REG_COL_SHELL:    cextra_reg <= pwdata[W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CONTROL:      rd_word = W'(ctrl_reg);
            REG_MAJOR:        rd_word = major_reg;
            REG_MINOR:        rd_word = minor_reg;
            REG_SHELL:        rd_word = shellt_reg;
            REG_DER_OFFSET:   rd_word = doff_reg;
            REG_COL_BASE:     rd_word = cbase_reg;
            REG_COL_PER_ITER: rd_word = citer_reg;
            REG_COL_SHELL:    rd_word = cextra_reg;
        endcase
    end

    assign prdata = DW'(rd_word);

    // Tube offset; the user must keep it static while items are in flight, the block does not enforce it
    assign shell_on = ctrl_reg[CTL_SHELL];
    assign toff     = shell_on ? ssub(shellt_reg, minor_reg) : sneg(minor_reg);

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Stage 1: unpack and swap axes
    always_comb
    begin
        item1_next.x     = s_tdata[0*W +: W];
        item1_next.y     = s_tdata[1*W +: W];
        item1_next.z     = s_tdata[2*W +: W];
        item1_next.rdist = s_tdata[3*W +: W];
        item1_next.div   = s_tdata[4*W +: W];
        item1_next.col   = s_tdata[5*W +: W];
        item1_next.cadd  = '0;
        item1_next.it    = s_tdata[6*W +: 8];
        if (ctrl_reg[CTL_SWAPXZ])
        begin
            item1_next.x = s_tdata[2*W +: W];
            item1_next.z = s_tdata[0*W +: W];
        end
        if (ctrl_reg[CTL_SWAPYZ])
        begin
            item1_next.y = item1_next.z;
            item1_next.z = s_tdata[1*W +: W];
        end
    end

    // Stage 2: magnitudes, divisor, iteration product
    always_comb
    begin
        item2_next     = item1_reg;
        item2_next.div = sadd(item1_reg.div, doff_reg);
        mx2_next       = magn(item1_reg.x);
        my2_next       = magn(item1_reg.y);
        prod2_next     = $signed(citer_reg) * $signed({1'b0, item1_reg.it});
    end

    // Stage 3 saturation of the iteration product
    always_comb
    begin
        if (prod2_reg[W+8:W-1] == '0 || prod2_reg[W+8:W-1] == '1)
            cis3_next = prod2_reg[W-1:0];
        else
            cis3_next = prod2_reg[W+8] ? MINV : MAXV;
    end

    // Stage 4: colour term
    always_comb
    begin
        item4_next      = item3_reg;
        item4_next.cadd = sadd(cbase_reg, cis3_reg);
    end

    tdf_isqrt #(
        .W      (W),
        .SIDE_W ($bits(item_t))
    ) u_sqrt_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{advance: en, valid: v4_reg}),
        .rad      (rad4_reg),
        .side_in  (item4_reg),
        .out_valid(sq1_valid),
        .root     (root1),
        .side_out (sq1_item)
    );

    // Stages 5-6: ring offset, Chebyshev candidate
    assign t1_5_next  = ssub(rsat(root1), major_reg);
    assign cheb6_next = (sabs(t1_5_reg) > sabs(item5_reg.z)) ? sabs(t1_5_reg)
                                                             : sabs(item5_reg.z);

    tdf_isqrt #(
        .W      (W),
        .SIDE_W ($bits(item_t) + W)
    ) u_sqrt_tube (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{advance: en, valid: v8_reg}),
        .rad      (rad8_reg),
        .side_in  ({cheb8_reg, item8_reg}),
        .out_valid(sq2_valid),
        .root     (root2),
        .side_out ({sq2_cheb, sq2_item})
    );

    // Stages 9-11: tube distance, shell, clips
    assign raw9_next = sadd(ctrl_reg[CTL_CHEBYSHEV] ? sq2_cheb : rsat(root2), toff);

    always_comb
    begin
        logic [W-1:0] sh;
        logic [W-1:0] cx;
        sh           = ssub(sabs(raw9_reg), shellt_reg);
        torsh10_next = shell_on ? (sh[W-1] ? '0 : sh) : raw9_reg;
        rawp10_next  = sadd(raw9_reg, shellt_reg);
        extra11_next = shell_on && ($signed(torsh10_reg) >= $signed(rawp10_reg));
        cx           = ctrl_reg[CTL_CLIPX] ? smax(torsh10_reg, sneg(item10_reg.x))
                                           : torsh10_reg;
        torf11_next  = ctrl_reg[CTL_CLIPY] ? smax(cx, sneg(item10_reg.y)) : cx;
    end

    // Stage 12: divider operands and colour shell term
    always_comb
    begin
        item12_next        = item11_reg;
        item12_next.cadd   = extra11_reg ? sadd(item11_reg.cadd, cextra_reg) : item11_reg.cadd;
        qf12_next.neg      = torf11_reg[W-1] != item11_reg.div[W-1];
        qf12_next.numz     = (torf11_reg == '0);
        qf12_next.denz     = (item11_reg.div == '0);
        qf12_next.numneg   = torf11_reg[W-1];
    end

    tdf_div #(
        .W      (W),
        .F      (F),
        .SIDE_W ($bits(item_t) + $bits(qflags_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{advance: en, valid: v12_reg}),
        .num      (nm12_reg),
        .den      (dm12_reg),
        .side_in  ({qf12_reg, item12_reg}),
        .out_valid(dv_valid),
        .quo      (quo),
        .side_out ({dv_qf, dv_item})
    );

    // Stage 13: quotient sign and saturation
    always_comb
    begin
        logic [NW-1:0] lim;
        lim = {{F{1'b0}}, (dv_qf.neg ? MINV : MAXV)};
        priority if (dv_qf.numz)
            q13_next = '0;
        else if (dv_qf.denz)
            q13_next = dv_qf.numneg ? MINV : MAXV;
        else if (quo > lim)
            q13_next = dv_qf.neg ? MINV : MAXV;
        else
            q13_next = dv_qf.neg ? (~quo[W-1:0] + 1'b1) : quo[W-1:0];
    end

    // Final: minimum distance and colour update
    always_comb
    begin
        logic win;
        nd_out  = ($signed(q13_reg) < $signed(item13_reg.rdist)) ? q13_reg : item13_reg.rdist;
        win     = (item13_reg.it >= ctrl_reg[CTL_START_LSB +: 8])
               && (item13_reg.it < ctrl_reg[CTL_STOP_LSB +: 8]);
        col_out = item13_reg.col;
        if (ctrl_reg[CTL_COLOUR] && (nd_out != item13_reg.rdist) && win)
            col_out = ctrl_reg[CTL_ACCUM] ? sadd(item13_reg.col, item13_reg.cadd)
                                          : item13_reg.cadd;
    end

    assign p_data = {col_out, nd_out};

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= sq1_valid;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= sq2_valid;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= dv_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg   <= item1_next;
            item2_reg   <= item2_next;
            mx2_reg     <= mx2_next;
            my2_reg     <= my2_next;
            prod2_reg   <= prod2_next;
            item3_reg   <= item2_reg;
            sqx3_reg    <= mx2_reg * mx2_reg;
            sqy3_reg    <= my2_reg * my2_reg;
            cis3_reg    <= cis3_next;
            item4_reg   <= item4_next;
            rad4_reg    <= sqx3_reg + sqy3_reg;
            item5_reg   <= sq1_item;
            t1_5_reg    <= t1_5_next;
            item6_reg   <= item5_reg;
            mt6_reg     <= magn(t1_5_reg);
            mz6_reg     <= magn(item5_reg.z);
            cheb6_reg   <= cheb6_next;
            item7_reg   <= item6_reg;
            sqt7_reg    <= mt6_reg * mt6_reg;
            sqz7_reg    <= mz6_reg * mz6_reg;
            cheb7_reg   <= cheb6_reg;
            item8_reg   <= item7_reg;
            rad8_reg    <= sqt7_reg + sqz7_reg;
            cheb8_reg   <= cheb7_reg;
            item9_reg   <= sq2_item;
            raw9_reg    <= raw9_next;
            item10_reg  <= item9_reg;
            torsh10_reg <= torsh10_next;
            rawp10_reg  <= rawp10_next;
            item11_reg  <= item10_reg;
            torf11_reg  <= torf11_next;
            extra11_reg <= extra11_next;
            item12_reg  <= item12_next;
            nm12_reg    <= magn(torf11_reg);
            dm12_reg    <= magn(item11_reg.div);
            qf12_reg    <= qf12_next;
            item13_reg  <= dv_item;
            q13_reg     <= q13_next;
        end
    end

    // Output register and skid entry
    assign take = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (v13_reg)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (v13_reg)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= p_data;
            end
            else
            begin
                out_data_reg <= p_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    `TDF_ASSERT_IMPL(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `TDF_ASSERT_NEXT(a_stall_fills_skid,
        out_valid_reg && !m_tready && v13_reg && !skid_valid_reg, skid_valid_reg)
    `TDF_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_tready,
        !skid_valid_reg && out_valid_reg)
    `TDF_ASSERT_NEXT(a_ctrl_write, cfg_wr && cfg_idx == REG_CONTROL,
        ctrl_reg == $past(pwdata[CTL_WIDTH-1:0]))

endmodule

`default_nettype wire

[sim/tb_torus_distance_field_step_unit.sv]
`timescale 1ns / 100ps

module tb_torus_distance_field_step_unit;
    import tdf_pkg::*;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 193;
    localparam int DRAIN_CYCLES = 140;
    localparam int STUCK_LIMIT = 5000;

    typedef struct {
        logic [31:0] x, y, z, rdist, der, col;
        logic [7:0]  iter;
    } point_beat_t;

    typedef struct {
        logic [31:0] ndist, col;
    } step_result_t;

    // Directed row: literal result used only where marked
    typedef struct {
        point_beat_t  pt;
        bit           lit;
        step_result_t res;
    } directed_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // x, y, z, distance, derivative, colour, iteration (lowest bits first)
    logic [199:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // new distance, new colour (lowest bits first)
    logic [63:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the register file
    logic [23:0]  sh_control;
    longint       sh_major, sh_minor, sh_shell, sh_doff, sh_cbase, sh_citer, sh_cextra;

    step_result_t pending_results[$];
    int           mismatches;
    int           stuck_cycles;
    bit           gaps_on;
    int           ready_hold;

    torus_distance_field_step_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Saturating Q16.16 helpers
    function automatic longint sat(longint v);
        return v > MAXV ? MAXV : (v < MINV ? MINV : v);
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint vmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint sneg(longint a);
        return sat(-a);
    endfunction

    function automatic longint sabs(longint a);
        return a < 0 ? sat(-a) : a;
    endfunction

    // floor(sqrt(a^2 + b^2)), saturated
    function automatic longint hypot_floor(longint a, longint b);
        logic [127:0] sum;
        logic [63:0]  ma, mb, root, cand;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        sum = 128'(ma) * 128'(ma) + 128'(mb) * 128'(mb);
        root = 0;
        for (int b_i = 34; b_i >= 0; b_i--)
        begin
            cand = root | (64'd1 << b_i);
            if (128'(cand) * 128'(cand) <= sum)
                root = cand;
        end
        return root > MAXV ? MAXV : longint'(root);
    endfunction

    // (num << 16) / den, truncated, saturated; zero divisor saturates by sign
    function automatic longint fixed_div(longint num, longint den);
        logic [127:0] quo;
        logic [63:0]  mn, md;
        bit           neg;
        if (num == 0)
            return 0;
        if (den == 0)
            return num > 0 ? MAXV : MINV;
        neg = (num < 0) != (den < 0);
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        quo = (128'(mn) << 16) / 128'(md);
        if (neg)
            return quo > 128'(64'd2147483648) ? MINV : -longint'(quo[63:0]);
        return quo > 128'(MAXV) ? MAXV : longint'(quo[63:0]);
    endfunction

    // Expected outcome of one torus step under the shadow registers
    function automatic step_result_t torus_step(point_beat_t p);
        longint x, y, z, run_d, col, swp, t1, ofs, tor, raw, q, nd, term;
        int     it, start_it, stop_it;
        bit     shell;
        step_result_t r;
        x = sx(p.x);
        y = sx(p.y);
        z = sx(p.z);
        run_d = sx(p.rdist);
        col = sx(p.col);
        it = p.iter;
        shell = sh_control[CTL_SHELL];
        start_it = sh_control[CTL_START_LSB +: 8];
        stop_it = sh_control[CTL_STOP_LSB +: 8];
        if (sh_control[CTL_SWAPXZ])
        begin
            swp = x; x = z; z = swp;
        end
        if (sh_control[CTL_SWAPYZ])
        begin
            swp = y; y = z; z = swp;
        end
        t1 = sat(hypot_floor(x, y) - sh_major);
        ofs = shell ? sat(sh_shell - sh_minor) : sneg(sh_minor);
        if (sh_control[CTL_CHEBYSHEV])
            tor = sat(vmax(sabs(t1), sabs(z)) + ofs);
        else
            tor = sat(hypot_floor(t1, z) + ofs);
        raw = tor;
        if (shell)
        begin
            tor = vmax(sat(sabs(tor) - sh_shell), 0);
            t1 = tor;
        end
        if (sh_control[CTL_CLIPX])
            tor = vmax(tor, sneg(x));
        if (sh_control[CTL_CLIPY])
            tor = vmax(tor, sneg(y));
        q = fixed_div(tor, sat(sx(p.der) + sh_doff));
        nd = q < run_d ? q : run_d;
        if (sh_control[CTL_COLOUR] && nd != run_d && it >= start_it && it < stop_it)
        begin
            term = sat(sh_cbase + sat(sh_citer * it));
            if (shell && t1 >= sat(raw + sh_shell))
                term = sat(term + sh_cextra);
            col = sh_control[CTL_ACCUM] ? sat(col + term) : term;
        end
        r.ndist = nd[31:0];
        r.col = col[31:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none when idling is off
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1, 2: return 32'($signed($urandom_range(0, 524288)) - 262144);
            3: return $urandom;
            4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic point_beat_t rand_point();
        point_beat_t p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        case ($urandom_range(0, 4))
            0: p.rdist = $urandom;
            1: p.rdist = 32'h7fff_ffff;
            2: p.rdist = $urandom_range(0, 20000);
            default: p.rdist = $urandom_range(0, 300000);
        endcase
        case ($urandom_range(0, 5))
            0: p.der = 0;
            1: p.der = $urandom;
            2: p.der = -32'($urandom_range(1, 200000));
            default: p.der = $urandom_range(16384, 400000);
        endcase
        p.col = $urandom;
        p.iter = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12));
        return p;
    endfunction

    // APB write: setup then access, no wait states, then idle before the shadow copy is updated
    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CONTROL:      sh_control = val[23:0];
            REG_MAJOR:        sh_major = sx(val);
            REG_MINOR:        sh_minor = sx(val);
            REG_SHELL:        sh_shell = sx(val);
            REG_DER_OFFSET:   sh_doff = sx(val);
            REG_COL_BASE:     sh_cbase = sx(val);
            REG_COL_PER_ITER: sh_citer = sx(val);
            default:          sh_cextra = sx(val);
        endcase
    endtask

    // Send one point; expectation queued ahead of acceptance
    task automatic send_point(point_beat_t p, bit lit, step_result_t lit_res);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_results.push_back(lit ? lit_res : torus_step(p));
        s_tvalid <= 1'b1;
        s_tdata <= {p.iter, p.col, p.der, p.rdist, p.z, p.y, p.x};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls and in-order compare
    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: dist=%h col=%h", m_tdata[31:0], m_tdata[63:32]);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.ndist !== m_tdata[31:0] || want.col !== m_tdata[63:32])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat mismatch: dist exp=%h got=%h col exp=%h got=%h",
                                     want.ndist, m_tdata[31:0], want.col, m_tdata[63:32]);
                    end
                end
            end
            if (ready_hold > 0)
                ready_hold <= ready_hold - 1;
            else
            begin
                ready_hold <= gap_len();
                m_tready <= (ready_hold == 0) ? ($urandom_range(0, 1) || !gaps_on) : 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat moving and no APB access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("** torus_distance_field_step_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        directed_row_t rows[$];
        directed_row_t row;
        step_result_t  none;
        logic [31:0]   ctl;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        stuck_cycles = 0;
        ready_hold = 0;
        gaps_on = 1'b1;
        none = '{ndist: '0, col: '0};
        sh_control = 0;
        sh_major = 65536;
        sh_minor = 32768;
        sh_shell = 328;
        sh_doff = 0;
        sh_cbase = 0;
        sh_citer = 0;
        sh_cextra = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset settings. Zero derivative with a positive torus
        // distance saturates, so the running distance survives untouched.
        row.lit = 1;
        row.pt = '{x: 0, y: 0, z: 0, rdist: 0, der: 0, col: 32'h1234_5678, iter: 0};
        row.res = '{ndist: 0, col: 32'h1234_5678};
        rows.push_back(row);
        row.pt = '{x: 0, y: 0, z: 0, rdist: 32'h8000_0000, der: 0, col: 32'h8000_0000,
                   iter: 255};
        row.res = '{ndist: 32'h8000_0000, col: 32'h8000_0000};
        rows.push_back(row);
        row.pt = '{x: 32'h7fff_ffff, y: 32'h7fff_ffff, z: 32'h7fff_ffff, rdist: 32'h7fff_ffff,
                   der: 0, col: 32'h7fff_ffff, iter: 8'hff};
        row.res = '{ndist: 32'h7fff_ffff, col: 32'h7fff_ffff};
        rows.push_back(row);
        row.lit = 0;
        row.res = none;
        row.pt = '{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000, rdist: 32'h7fff_ffff,
                   der: 32'h0001_0000, col: 0, iter: 1};
        rows.push_back(row);
        row.pt = '{x: 32'h0001_0000, y: 0, z: 0, rdist: 32'h7fff_ffff,
                   der: 32'h0001_0000, col: 5, iter: 2};
        rows.push_back(row);
        row.pt = '{x: 32'h0001_8000, y: 0, z: 0, rdist: 32'h7fff_ffff,
                   der: 32'hffff_0000, col: 5, iter: 3};
        rows.push_back(row);
        row.pt = '{x: 0, y: 32'h0003_0000, z: 32'hfffe_0000, rdist: 32'h0000_0100,
                   der: 32'h0000_0001, col: 32'hffff_ffff, iter: 4};
        rows.push_back(row);
        row.pt = '{x: 32'h7fff_ffff, y: 32'h8000_0000, z: 32'h0000_0001, rdist: 32'h8000_0001,
                   der: 32'h7fff_ffff, col: 32'h5555_aaaa, iter: 8'haa};
        rows.push_back(row);
        row.pt = '{x: 32'h0000_c000, y: 32'h0000_4000, z: 32'h0000_2000, rdist: 32'h0010_0000,
                   der: 32'h8000_0000, col: 32'haaaa_5555, iter: 8'h55};
        rows.push_back(row);
        foreach (rows[i])
            send_point(rows[i].pt, rows[i].lit, rows[i].res);
        wait_drained();

        // Setting phases: all-max, all-min, then random, each with random points
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            gaps_on = (ph % 4) != 3;
            if (ph == 0)
            begin
                reg_write(REG_CONTROL, 32'h00ff_00ff);
                reg_write(REG_MAJOR, 32'h7fff_ffff);
                reg_write(REG_MINOR, 32'h7fff_ffff);
                reg_write(REG_SHELL, 32'h7fff_ffff);
                reg_write(REG_DER_OFFSET, 32'h7fff_ffff);
                reg_write(REG_COL_BASE, 32'h7fff_ffff);
                reg_write(REG_COL_PER_ITER, 32'h7fff_ffff);
                reg_write(REG_COL_SHELL, 32'h7fff_ffff);
            end
            else if (ph == 1)
            begin
                reg_write(REG_CONTROL, 32'h00ff_00c4);
                reg_write(REG_MAJOR, 32'h8000_0000);
                reg_write(REG_MINOR, 32'h8000_0000);
                reg_write(REG_SHELL, 32'h8000_0000);
                reg_write(REG_DER_OFFSET, 32'h8000_0000);
                reg_write(REG_COL_BASE, 32'h8000_0000);
                reg_write(REG_COL_PER_ITER, 32'h8000_0000);
                reg_write(REG_COL_SHELL, 32'h8000_0000);
            end
            else
            begin
                ctl = $urandom_range(0, 255);
                ctl[CTL_COLOUR] = $urandom_range(0, 3) != 0;
                ctl[CTL_START_LSB +: 8] = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
                ctl[CTL_STOP_LSB +: 8] = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(4, 255));
                reg_write(REG_CONTROL, ctl);
                reg_write(REG_MAJOR, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144));
                reg_write(REG_MINOR, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
                reg_write(REG_SHELL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000));
                reg_write(REG_DER_OFFSET, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 65536));
                reg_write(REG_COL_BASE, $urandom);
                reg_write(REG_COL_PER_ITER, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536));
                reg_write(REG_COL_SHELL, $urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_point(rand_point(), 0, none);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** torus_distance_field_step_unit: PASSED **");
        else
            $display("** torus_distance_field_step_unit: FAILED **");
        $finish;
    end

endmodule
